### src/mrah_pkg.sv
`timescale 1ns / 1ps

package mrah_pkg;

    localparam int WORD_W  = 32;
    localparam int CMD_W   = 5;
    localparam int SHAMT_W = 5;
    localparam int REG_W   = 5;

    // operation codes
    localparam logic [CMD_W-1:0] CMD_AND   = 5'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 5'd1;
    localparam logic [CMD_W-1:0] CMD_ADDU  = 5'd2;
    localparam logic [CMD_W-1:0] CMD_SUB   = 5'd3;
    localparam logic [CMD_W-1:0] CMD_SUBU  = 5'd4;
    localparam logic [CMD_W-1:0] CMD_SLT   = 5'd5;
    localparam logic [CMD_W-1:0] CMD_SLTU  = 5'd6;
    localparam logic [CMD_W-1:0] CMD_DIV   = 5'd7;
    localparam logic [CMD_W-1:0] CMD_DIVU  = 5'd8;
    localparam logic [CMD_W-1:0] CMD_MULT  = 5'd9;
    localparam logic [CMD_W-1:0] CMD_MULTU = 5'd10;
    localparam logic [CMD_W-1:0] CMD_NOR   = 5'd11;
    localparam logic [CMD_W-1:0] CMD_OR    = 5'd12;
    localparam logic [CMD_W-1:0] CMD_XOR   = 5'd13;
    localparam logic [CMD_W-1:0] CMD_SLLV  = 5'd14;
    localparam logic [CMD_W-1:0] CMD_SLL   = 5'd15;
    localparam logic [CMD_W-1:0] CMD_SRAV  = 5'd16;
    localparam logic [CMD_W-1:0] CMD_SRA   = 5'd17;
    localparam logic [CMD_W-1:0] CMD_SRLV  = 5'd18;
    localparam logic [CMD_W-1:0] CMD_SRL   = 5'd19;
    localparam logic [CMD_W-1:0] CMD_MFHI  = 5'd20;
    localparam logic [CMD_W-1:0] CMD_MFLO  = 5'd21;
    localparam logic [CMD_W-1:0] CMD_MTHI  = 5'd22;
    localparam logic [CMD_W-1:0] CMD_MTLO  = 5'd23;

    // request to the multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
        logic is_signed;
    } mdu_req_t;

endpackage

### src/mrah_alu.sv
`timescale 1ns / 1ps

module mrah_alu
    import mrah_pkg::*;
(
    input  logic [CMD_W-1:0]   cmd,
    input  logic [WORD_W-1:0]  op_a,
    input  logic [WORD_W-1:0]  op_b,
    input  logic [SHAMT_W-1:0] shamt,
    input  logic [WORD_W-1:0]  hi_val,
    input  logic [WORD_W-1:0]  lo_val,
    output logic               we,
    output logic [WORD_W-1:0]  val
);

    logic [SHAMT_W-1:0] var_amt;
    logic [WORD_W-1:0]  sra_fix;
    logic [WORD_W-1:0]  sra_var;

    assign var_amt = op_a[SHAMT_W-1:0];
    assign sra_fix = $unsigned($signed(op_b) >>> shamt);
    assign sra_var = $unsigned($signed(op_b) >>> var_amt);

    always_comb
    begin
        we  = 1'b1;
        val = '0;
        unique case (cmd)
            CMD_AND:              val = op_a & op_b;
            CMD_ADD, CMD_ADDU:    val = op_a + op_b;
            CMD_SUB, CMD_SUBU:    val = op_a - op_b;
            CMD_SLT:              val = {{(WORD_W-1){1'b0}}, $signed(op_a) < $signed(op_b)};
            CMD_SLTU:             val = {{(WORD_W-1){1'b0}}, op_a < op_b};
            CMD_NOR:              val = ~(op_a | op_b);
            CMD_OR:               val = op_a | op_b;
            CMD_XOR:              val = op_a ^ op_b;
            CMD_SLLV:             val = op_b << var_amt;
            CMD_SLL:              val = op_b << shamt;
            CMD_SRAV:             val = sra_var;
            CMD_SRA:              val = sra_fix;
            CMD_SRLV:             val = op_b >> var_amt;
            CMD_SRL:              val = op_b >> shamt;
            CMD_MFHI:             val = hi_val;
            CMD_MFLO:             val = lo_val;
            default:              we  = 1'b0;
        endcase
    end

endmodule

### src/mrah_mdu.sv
`timescale 1ns / 1ps

module mrah_mdu
    import mrah_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mdu_req_t          req,
    input  logic [WORD_W-1:0] op_a,
    input  logic [WORD_W-1:0] op_b,
    output logic              done,
    output logic [WORD_W-1:0] res_hi,
    output logic [WORD_W-1:0] res_lo
);

    localparam int CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ITER,
        ST_FIX
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               done_reg;
    logic               is_div_reg;
    logic               neg_q_reg;
    logic               neg_r_reg;
    logic [WORD_W-1:0]  hi_part_reg;
    logic [WORD_W-1:0]  lo_part_reg;
    logic [WORD_W-1:0]  opb_reg;

    logic               a_neg;
    logic               b_neg;
    logic [WORD_W-1:0]  mag_a;
    logic [WORD_W-1:0]  mag_b;
    logic [WORD_W:0]    x_opnd;
    logic [WORD_W:0]    y_opnd;
    logic [WORD_W+1:0]  sum;
    logic               q_bit;
    logic [WORD_W-1:0]  hi_next;
    logic [WORD_W-1:0]  lo_next;
    logic [2*WORD_W-1:0] prod_neg;

    assign a_neg = req.is_signed & op_a[WORD_W-1];
    assign b_neg = req.is_signed & op_b[WORD_W-1];
    assign mag_a = a_neg ? (~op_a + 1'b1) : op_a;
    assign mag_b = b_neg ? (~op_b + 1'b1) : op_b;

    // shared adder: add for multiply steps, subtract for divide steps
    always_comb
    begin
        x_opnd = is_div_reg ? {hi_part_reg, lo_part_reg[WORD_W-1]} : {1'b0, hi_part_reg};
        y_opnd = (is_div_reg || lo_part_reg[0]) ? {1'b0, opb_reg} : '0;
        sum    = {1'b0, x_opnd} + ({1'b0, y_opnd} ^ {(WORD_W+2){is_div_reg}})
               + {{(WORD_W+1){1'b0}}, is_div_reg};
        q_bit  = ~sum[WORD_W+1];
        if (is_div_reg)
        begin
            hi_next = q_bit ? sum[WORD_W-1:0] : x_opnd[WORD_W-1:0];
            lo_next = {lo_part_reg[WORD_W-2:0], q_bit};
        end
        else
        begin
            hi_next = sum[WORD_W:1];
            lo_next = {sum[0], lo_part_reg[WORD_W-1:1]};
        end
    end

    assign prod_neg = ~{hi_part_reg, lo_part_reg} + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.start)
                    begin
                        state_reg   <= ST_ITER;
                        count_reg   <= '0;
                        is_div_reg  <= req.is_div;
                        neg_q_reg   <= a_neg ^ b_neg;
                        neg_r_reg   <= a_neg;
                        hi_part_reg <= '0;
                        lo_part_reg <= mag_a;
                        opb_reg     <= mag_b;
                    end
                end
                ST_ITER:
                begin
                    hi_part_reg <= hi_next;
                    lo_part_reg <= lo_next;
                    count_reg   <= count_reg + 1'b1;
                    if (count_reg == LAST_STEP)
                    begin
                        state_reg <= ST_FIX;
                    end
                end
                ST_FIX:
                begin
                    // sign correction of the magnitude result
                    if (is_div_reg)
                    begin
                        if (neg_q_reg)
                        begin
                            lo_part_reg <= ~lo_part_reg + 1'b1;
                        end
                        if (neg_r_reg)
                        begin
                            hi_part_reg <= ~hi_part_reg + 1'b1;
                        end
                    end
                    else if (neg_q_reg)
                    begin
                        hi_part_reg <= prod_neg[2*WORD_W-1:WORD_W];
                        lo_part_reg <= prod_neg[WORD_W-1:0];
                    end
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign res_hi = hi_part_reg;
    assign res_lo = lo_part_reg;

endmodule

### src/mips_rtype_alu_hilo.sv
`timescale 1ns / 1ps

// r-type execute unit with hi/lo registers
// input channel: in_valid / in_stall carries one decoded operation word
//   (command, first_operand, second_operand, shift_amount, dest_index)
// output channel: out_valid / out_stall carries one result word per input
//   (write_enable, write_index, write_value, divide_by_zero)
// sequence: logic, shift, compare and hi/lo moves load the output register
//   straight from the latched word; mult, multu, div and divu go through
//   the shared multiply/divide unit running one bit per cycle (32 steps, a
//   sign-fix step, a handoff state and the output load); a divide by zero
//   skips the unit
// flow: one word at a time, in_stall is high from accept until the
//   result is loaded into the output register
// the output register decouples the sides: a new word is taken while an
//   earlier result still waits on out_stall
// a stalled result holds its payload; a finished item waits until the
//   output register frees before hi/lo and the output are updated
// reset clears hi, lo, the state registers and the output valid
module mips_rtype_alu_hilo
    import mrah_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CMD_W-1:0]   command,
    input  logic [WORD_W-1:0]  first_operand,
    input  logic [WORD_W-1:0]  second_operand,
    input  logic [SHAMT_W-1:0] shift_amount,
    input  logic [REG_W-1:0]   dest_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               write_enable,
    output logic [REG_W-1:0]   write_index,
    output logic [WORD_W-1:0]  write_value,
    output logic               divide_by_zero
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MDU,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [WORD_W-1:0]   a_reg;
    logic [WORD_W-1:0]   b_reg;
    logic [SHAMT_W-1:0]  sh_reg;
    logic [REG_W-1:0]    rd_reg;
    logic                dz_reg;
    logic [WORD_W-1:0]   hi_reg;
    logic [WORD_W-1:0]   lo_reg;

    logic                out_valid_reg;
    logic                out_we_reg;
    logic [REG_W-1:0]    out_idx_reg;
    logic [WORD_W-1:0]   out_val_reg;
    logic                out_dz_reg;

    logic                accept;
    logic                is_div_in;
    logic                is_mul_in;
    logic                div_zero_in;
    logic                fire;
    logic                alu_we;
    logic [WORD_W-1:0]   alu_val;
    logic                mdu_done;
    logic [WORD_W-1:0]   mdu_hi;
    logic [WORD_W-1:0]   mdu_lo;
    logic                mdu_op_reg;
    mdu_req_t            mdu_req;

    assign accept      = in_valid && !in_stall;
    assign in_stall    = (state_reg != ST_IDLE);
    assign is_div_in   = (command == CMD_DIV) || (command == CMD_DIVU);
    assign is_mul_in   = (command == CMD_MULT) || (command == CMD_MULTU);
    assign div_zero_in = is_div_in && (second_operand == '0);

    // start the shared unit straight from the input word
    assign mdu_req.start     = accept && (is_mul_in || (is_div_in && !div_zero_in));
    assign mdu_req.is_div    = is_div_in;
    assign mdu_req.is_signed = (command == CMD_DIV) || (command == CMD_MULT);

    mrah_mdu u_mdu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mdu_req),
        .op_a   (first_operand),
        .op_b   (second_operand),
        .done   (mdu_done),
        .res_hi (mdu_hi),
        .res_lo (mdu_lo)
    );

    // combinational ALU operations work on the latched word
    mrah_alu u_alu
    (
        .cmd    (cmd_reg),
        .op_a   (a_reg),
        .op_b   (b_reg),
        .shamt  (sh_reg),
        .hi_val (hi_reg),
        .lo_val (lo_reg),
        .we     (alu_we),
        .val    (alu_val)
    );

    // result may load once the output register is free or being drained
    assign fire = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            hi_reg        <= '0;
            lo_reg        <= '0;
        end
        else
        begin
            // drained with nothing new to load
            if (out_valid_reg && !out_stall && !fire)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg    <= command;
                        a_reg      <= first_operand;
                        b_reg      <= second_operand;
                        sh_reg     <= shift_amount;
                        rd_reg     <= dest_index;
                        dz_reg     <= div_zero_in;
                        mdu_op_reg <= mdu_req.start;
                        state_reg  <= mdu_req.start ? ST_MDU : ST_DONE;
                    end
                end
                ST_MDU:
                begin
                    if (mdu_done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (fire)
                    begin
                        out_valid_reg <= 1'b1;
                        out_we_reg    <= alu_we;
                        out_idx_reg   <= rd_reg;
                        out_val_reg   <= alu_we ? alu_val : '0;
                        out_dz_reg    <= dz_reg;
                        // hi/lo written by the multiply/divide unit or moves
                        priority if (mdu_op_reg)
                        begin
                            hi_reg <= mdu_hi;
                            lo_reg <= mdu_lo;
                        end
                        else if (cmd_reg == CMD_MTHI)
                        begin
                            hi_reg <= a_reg;
                        end
                        else if (cmd_reg == CMD_MTLO)
                        begin
                            lo_reg <= a_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign write_enable   = out_we_reg;
    assign write_index    = out_idx_reg;
    assign write_value    = out_val_reg;
    assign divide_by_zero = out_dz_reg;

endmodule
